// ----- src/aats_pkg.sv -----
package aats_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AGE_BITS    = 16;

  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CTX_W   = 16;
  localparam int OP_W    = 10;
  localparam int PRI_W   = 16;
  localparam int BONUS_W = 8;
  localparam int LEVEL_W = 5;
  localparam int SCORE_W = ((AGE_BITS > PRI_W) ? AGE_BITS : PRI_W) + 2;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  localparam logic [BONUS_W-1:0] BONUS_RESET = BONUS_W'(8);

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_GRANTED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    CFG_AFFINITY_BONUS  = 1'b0,
    CFG_RECONFIG_ENABLE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CTX_W-1:0]    ctx;
    logic [OP_W-1:0]     op;
    logic [PRI_W-1:0]    pri;
    logic [AGE_BITS-1:0] age;
  } task_t;

  localparam int TASK_W = $bits(task_t);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [BONUS_W-1:0] bonus;
    logic [OP_W-1:0]    op;
  } rank_t;

  typedef struct packed {
    status_t             status;
    logic [CTX_W-1:0]    ctx;
    logic [OP_W-1:0]     op;
    logic [PRI_W-1:0]    pri;
    logic                reload;
    logic [LEVEL_W-1:0]  level;
  } result_t;

endpackage

// ----- src/aats_ram.sv -----
module aats_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/aats_rank.sv -----
module aats_rank (
  input  aats_pkg::task_t                 entry,
  input  logic                            first,
  input  logic                            loaded_valid,
  input  logic [aats_pkg::OP_W-1:0]       loaded_operator,
  input  logic [aats_pkg::BONUS_W-1:0]    affinity_bonus,
  input  aats_pkg::rank_t                 best,
  output aats_pkg::task_t                 aged,
  output aats_pkg::rank_t                 cand,
  output logic                            win
);

  logic match;

  always_comb begin
    aged = entry;
    if (entry.age != aats_pkg::AGE_MAX) begin
      aged.age = entry.age + aats_pkg::AGE_BITS'(1);
    end

    match = loaded_valid && (entry.op == loaded_operator);
    cand.bonus = match ? affinity_bonus : '0;
    cand.op    = entry.op;
    cand.score = aats_pkg::SCORE_W'(entry.pri) + aats_pkg::SCORE_W'(aged.age)
               + aats_pkg::SCORE_W'(cand.bonus);

    // strict order on score, then bonus, then operator: an equal candidate never displaces an earlier one
    win = first
       || (cand.score > best.score)
       || ((cand.score == best.score)
           && ((cand.bonus > best.bonus)
               || ((cand.bonus == best.bonus) && (cand.op > best.op))));
  end

endmodule

// ----- src/aging_affinity_task_scheduler_core.sv -----
// Insert, or dispatch on an empty queue, needs no pass: the result goes straight to S_RESULT.
// Dispatch on N tasks scans all N, then shifts the M tasks behind the winner down one slot.
// One read port serves an aging/scoring pass, then a compaction pass behind the winner.
// in_stall holds until the result is loaded for output; a stalled output delays that.
// Reset empties the queue, drops the loaded operator, restores config defaults; no memory clear.
module aging_affinity_task_scheduler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [aats_pkg::CTX_W-1:0]     context_id,
  input  logic [aats_pkg::OP_W-1:0]      operator_id,
  input  logic [aats_pkg::PRI_W-1:0]     task_priority,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [aats_pkg::CTX_W-1:0]     granted_context,
  output logic [aats_pkg::OP_W-1:0]      granted_operator,
  output logic [aats_pkg::PRI_W-1:0]     granted_priority,
  output logic                           reload_operator,
  output logic [aats_pkg::LEVEL_W-1:0]   queue_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [aats_pkg::BONUS_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                         state;
  logic [aats_pkg::CNT_W-1:0]     count;
  logic [aats_pkg::CNT_W-1:0]     idx;
  logic                           pend;
  logic [aats_pkg::ADDR_W-1:0]    pend_idx;
  logic [aats_pkg::ADDR_W-1:0]    best_idx;
  aats_pkg::rank_t                best;
  aats_pkg::task_t                best_task;
  aats_pkg::result_t              res;
  aats_pkg::result_t              out_res;
  logic [aats_pkg::OP_W-1:0]      loaded_operator;
  logic                           loaded_valid;
  logic [aats_pkg::BONUS_W-1:0]   affinity_bonus;
  logic                           reconfig_enable;

  logic                           in_accept;
  logic                           full;
  logic                           issue;
  logic                           we;
  logic [aats_pkg::ADDR_W-1:0]    waddr;
  aats_pkg::task_t                wdata;
  logic [aats_pkg::ADDR_W-1:0]    raddr;
  logic [aats_pkg::TASK_W-1:0]    rdata_bits;
  aats_pkg::task_t                rdata;
  aats_pkg::task_t                aged;
  aats_pkg::rank_t                cand;
  logic                           win;
  aats_pkg::task_t                new_task;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign full      = (count == aats_pkg::CNT_W'(aats_pkg::QUEUE_DEPTH));
  assign issue     = ((state == S_SCAN) || (state == S_SHIFT)) && (idx < count);
  assign raddr     = idx[aats_pkg::ADDR_W-1:0];
  assign rdata     = aats_pkg::task_t'(rdata_bits);

  always_comb begin
    new_task.ctx = context_id;
    new_task.op  = operator_id;
    new_task.pri = task_priority;
    new_task.age = '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = pend_idx;
    wdata = aged;
    if (in_accept && !mode && !full) begin
      we    = 1'b1;
      waddr = count[aats_pkg::ADDR_W-1:0];
      wdata = new_task;
    end else if (pend && (state == S_SCAN)) begin
      we    = 1'b1;
      waddr = pend_idx;
      wdata = aged;
    end else if (pend && (state == S_SHIFT)) begin
      // close the gap: each later entry moves down one slot
      we    = 1'b1;
      waddr = pend_idx - aats_pkg::ADDR_W'(1);
      wdata = rdata;
    end
  end

  aats_ram #(
    .WIDTH (aats_pkg::TASK_W),
    .DEPTH (aats_pkg::QUEUE_DEPTH)
  ) u_task_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata_bits)
  );

  aats_rank u_rank (
    .entry           (rdata),
    .first           (pend_idx == '0),
    .loaded_valid    (loaded_valid),
    .loaded_operator (loaded_operator),
    .affinity_bonus  (affinity_bonus),
    .best            (best),
    .aged            (aged),
    .cand            (cand),
    .win             (win)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      affinity_bonus  <= aats_pkg::BONUS_RESET;
      reconfig_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (aats_pkg::cfg_index_t'(cfg_index))
        aats_pkg::CFG_AFFINITY_BONUS:  affinity_bonus  <= cfg_data;
        aats_pkg::CFG_RECONFIG_ENABLE: reconfig_enable <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      count           <= '0;
      idx             <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
      loaded_operator <= '0;
      loaded_valid    <= 1'b0;
    end else begin
      if (!out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      if (issue) begin
        pend_idx <= idx[aats_pkg::ADDR_W-1:0];
        idx      <= idx + aats_pkg::CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            res.ctx    <= '0;
            res.op     <= '0;
            res.pri    <= '0;
            res.reload <= 1'b0;
            if (!mode) begin
              if (full) begin
                res.status <= aats_pkg::STATUS_FULL;
                res.level  <= aats_pkg::LEVEL_W'(count);
              end else begin
                res.status <= aats_pkg::STATUS_INSERTED;
                res.level  <= aats_pkg::LEVEL_W'(count + aats_pkg::CNT_W'(1));
                count      <= count + aats_pkg::CNT_W'(1);
              end
              state <= S_RESULT;
            end else if (count == '0) begin
              res.status <= aats_pkg::STATUS_EMPTY;
              res.level  <= '0;
              state      <= S_RESULT;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend && win) begin
            best      <= cand;
            best_idx  <= pend_idx;
            best_task <= aged;
          end
          if (!issue && !pend) begin
            idx   <= aats_pkg::CNT_W'(best_idx) + aats_pkg::CNT_W'(1);
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (!issue && !pend) begin
            count      <= count - aats_pkg::CNT_W'(1);
            res.status <= aats_pkg::STATUS_GRANTED;
            res.ctx    <= best_task.ctx;
            res.op     <= best_task.op;
            res.pri    <= best_task.pri;
            res.reload <= reconfig_enable;
            res.level  <= aats_pkg::LEVEL_W'(count - aats_pkg::CNT_W'(1));
            if (reconfig_enable) begin
              loaded_operator <= best_task.op;
              loaded_valid    <= 1'b1;
            end
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign status           = out_res.status;
  assign granted_context  = out_res.ctx;
  assign granted_operator = out_res.op;
  assign granted_priority = out_res.pri;
  assign reload_operator  = out_res.reload;
  assign queue_level      = out_res.level;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= aats_pkg::CNT_W'(aats_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> count != '0)
    else $error("scan or compaction with empty queue");

  a_pend_in_pass: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SCAN || state == S_SHIFT))
    else $error("memory read pending outside a pass");

  a_dispatch_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && !issue && !pend) |=> count == $past(count) - aats_pkg::CNT_W'(1))
    else $error("dispatch did not remove one task");

endmodule
